// ----- rtl/u8d_pkg.sv -----
`default_nettype none

package u8d_pkg;

  // Width of the character counter; the reported index is clamped to 32 bits.
  localparam int unsigned CountBits = 32;

  localparam int unsigned CpBits  = 31;
  localparam int unsigned IdxBits = 32;
  localparam int unsigned RemBits = 3;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StMalformed = 2'd1,
    StTruncated = 2'd2,
    StSurrogate = 2'd3
  } status_e;

  typedef struct packed {
    logic [RemBits-1:0]   rem;
    logic [CpBits-1:0]    part;
    logic [CountBits-1:0] cnt;
  } dec_state_t;

  typedef struct packed {
    logic [CpBits-1:0]  code_point;
    status_e            status;
    logic [IdxBits-1:0] char_index;
  } dec_result_t;

  localparam logic [CpBits-1:0] SurrLo = CpBits'(32'h0000_D800);
  localparam logic [CpBits-1:0] SurrHi = CpBits'(32'h0000_DFFF);

  function automatic logic [IdxBits-1:0] clamp_idx(input logic [CountBits-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    if (w > 64'h0000_0000_FFFF_FFFF) begin
      return '1;
    end
    return w[IdxBits-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/u8d_if.sv -----
`default_nettype none

// Byte channel into the decoder.
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

// Decoded character channel out of the decoder.
interface u8d_out_if;
  logic                valid;
  logic                ready;
  logic [30:0]         code_point;
  u8d_pkg::status_e    status;
  logic [31:0]         char_index;

  modport source (output valid, output code_point, output status, output char_index,
                  input ready);
  modport sink   (input valid, input code_point, input status, input char_index,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/utf8_stream_decoder.sv -----
`default_nettype none

// UTF-8 stream decoder.
// in_i  : one beat per raw byte (data_byte), end_of_text set on the string's
//         last byte.
// out_o : one beat per decoded character or error: code_point, status
//         (ok / malformed / truncated / surrogate) and char_index, the index
//         of the character within its string (saturating, clamped to 32 bits).
// Bytes in the middle of a multi-byte sequence produce no output beat.
// A byte accepted on in_i waits in the input register; its result then moves
// to the result register on out_o. Throughput: one byte per cycle while out_o
// does not stall; the decode is one combinational pass between the registers.
// Backpressure: the result register and the input register together hold
// two items; while out_o stalls, in_i keeps taking beats until the input
// register holds a byte that produces a result. in_i.ready is high whenever
// out_o.valid is low.
// Reset (rst_ni low, asynchronous): both registers empty, decoder idle,
// character counter zero. end_of_text also returns the decoder to that
// state after its byte.
module utf8_stream_decoder import u8d_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  u8d_in_if.sink     in_i,
  u8d_out_if.source  out_o
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eot_q;

  // decoder state
  dec_state_t st_q, st_d;

  // result register
  logic        out_vld_q;
  dec_result_t out_res_q;

  logic        res_vld;
  dec_result_t res;
  logic        out_free;
  logic        advance;
  logic        in_accept;

  u8d_decode u_decode (
    .st_i      (st_q),
    .byte_i    (in_byte_q),
    .eot_i     (in_eot_q),
    .nxt_o     (st_d),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // The held byte moves on when it yields nothing or the result slot frees up.
  assign out_free  = !out_vld_q || out_o.ready;
  assign advance   = in_vld_q && (!res_vld || out_free);
  assign in_i.ready = !in_vld_q || advance;
  assign in_accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      in_vld_q <= in_accept || (in_vld_q && !advance);
      if (advance) begin
        st_q <= st_d;
      end
      if (out_free) begin
        out_vld_q <= advance && res_vld;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_i.data_byte;
      in_eot_q  <= in_i.end_of_text;
    end
    if (out_free && advance && res_vld) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.code_point = out_res_q.code_point;
  assign out_o.status     = out_res_q.status;
  assign out_o.char_index = out_res_q.char_index;

endmodule

`default_nettype wire

// ----- rtl/u8d_decode.sv -----
`default_nettype none

module u8d_decode import u8d_pkg::*; (
  input  dec_state_t  st_i,
  input  logic [7:0]  byte_i,
  input  logic        eot_i,
  output dec_state_t  nxt_o,
  output logic        res_vld_o,
  output dec_result_t res_o
);

  logic [CountBits-1:0] cnt_inc;
  logic [CpBits-1:0]    shifted;
  logic [RemBits-1:0]   rem_dec;
  logic [7:0]           lead_mask;
  logic [RemBits-1:0]   lead_rem;

  assign cnt_inc = (st_i.cnt == '1) ? st_i.cnt : st_i.cnt + 1'b1;
  assign shifted = {st_i.part[CpBits-7:0], byte_i[5:0]};
  assign rem_dec = st_i.rem - 1'b1;

  // Count of continuation bytes and payload mask from the lead byte's leading ones.
  always_comb begin
    if (!byte_i[5]) begin
      lead_rem = 3'd1; lead_mask = 8'h1F;
    end else if (!byte_i[4]) begin
      lead_rem = 3'd2; lead_mask = 8'h0F;
    end else if (!byte_i[3]) begin
      lead_rem = 3'd3; lead_mask = 8'h07;
    end else if (!byte_i[2]) begin
      lead_rem = 3'd4; lead_mask = 8'h03;
    end else begin
      lead_rem = 3'd5; lead_mask = 8'h01;
    end
  end

  always_comb begin
    nxt_o     = st_i;
    res_vld_o = 1'b0;
    res_o.code_point = '0;
    res_o.status     = StOk;
    res_o.char_index = clamp_idx(st_i.cnt);

    if (st_i.rem == '0) begin
      if (!byte_i[7]) begin
        res_vld_o        = 1'b1;
        res_o.code_point = CpBits'(byte_i);
        nxt_o.cnt        = cnt_inc;
      end else if (!byte_i[6] || byte_i[7:1] == 7'h7F) begin
        res_vld_o    = 1'b1;
        res_o.status = StMalformed;
        nxt_o.rem    = '0;
        nxt_o.part   = '0;
      end else begin
        nxt_o.part = CpBits'(byte_i & lead_mask);
        nxt_o.rem  = lead_rem;
        if (eot_i) begin
          res_vld_o    = 1'b1;
          res_o.status = StTruncated;
        end
      end
    end else if (byte_i[7:6] != 2'b10) begin
      res_vld_o    = 1'b1;
      res_o.status = StMalformed;
      nxt_o.rem    = '0;
      nxt_o.part   = '0;
    end else begin
      nxt_o.part = shifted;
      nxt_o.rem  = rem_dec;
      if (rem_dec == '0) begin
        res_vld_o  = 1'b1;
        nxt_o.part = '0;
        if (shifted >= SurrLo && shifted <= SurrHi) begin
          res_o.status = StSurrogate;
        end else begin
          res_o.code_point = shifted;
          nxt_o.cnt        = cnt_inc;
        end
      end else if (eot_i) begin
        res_vld_o    = 1'b1;
        res_o.status = StTruncated;
      end
    end

    // Last byte of the string: start the next string from scratch.
    if (eot_i) begin
      nxt_o = '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/u8d_checker.sv -----
`default_nettype none

module u8d_checker import u8d_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [30:0] code_point_i,
  input wire status_e     status_i,
  input wire logic [31:0] char_index_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(code_point_i)
      && $stable(status_i) && $stable(char_index_i))
    else $error("result changed while stalled");

  // errors carry no code point
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != StOk |-> code_point_i == '0)
    else $error("error beat with nonzero code point");

  // an empty output stage never blocks the input
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // a fresh result comes from a byte accepted on in_i and passed through the input register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without matching input beat");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .code_point_i (out_o.code_point),
  .status_i     (out_o.status),
  .char_index_i (out_o.char_index)
);

`default_nettype wire
